// ----- rtl/core/vsif_pkg.sv -----
// ----------------------------------------------------------------------------
// vsif_pkg
// Types and constants shared by the vendor-specific infoframe builder.
// ----------------------------------------------------------------------------
package vsif_pkg;

  typedef struct packed {
    logic [2:0]  format_3d;
    logic [7:0]  ext_vic;
    logic [15:0] horiz_total;
    logic [15:0] vert_total;
  } in_t;

  typedef struct packed {
    logic       packet_sent;
    logic [3:0] byte_pos;
    logic [7:0] byte_value;
    logic       last_byte;
  } out_t;

  typedef struct packed {
    logic       sent;
    logic       len6;
    logic [7:0] pb4;
    logic [7:0] pb5;
    logic [7:0] csum;
  } desc_t;

  localparam logic [7:0]  VsifType    = 8'h81;
  localparam logic [7:0]  VsifVersion = 8'h01;
  localparam logic [7:0]  OuiByte0    = 8'h03;
  localparam logic [7:0]  OuiByte1    = 8'h0C;
  localparam logic [7:0]  OuiByte2    = 8'h00;
  localparam logic [7:0]  Fmt3d       = 8'h40;
  localparam logic [7:0]  FmtExtRes   = 8'h20;
  localparam logic [7:0]  StructSbs   = 8'h80;
  localparam logic [7:0]  StructTb    = 8'h60;
  localparam logic [7:0]  LenNormal   = 8'd5;
  localparam logic [7:0]  LenSbs      = 8'd6;
  localparam logic [15:0] VicMinHtot  = 16'd3840;
  localparam logic [15:0] VicMinVtot  = 16'd2160;

  localparam logic [2:0] F3dNone     = 3'd0;
  localparam logic [2:0] F3dSbs      = 3'd3;
  localparam logic [2:0] F3dSbsSw    = 3'd4;
  localparam logic [2:0] F3dTb       = 3'd5;
  localparam logic [2:0] F3dTbSw     = 3'd6;

  localparam logic [3:0] PosHb0  = 4'd0;
  localparam logic [3:0] PosHb1  = 4'd1;
  localparam logic [3:0] PosHb2  = 4'd2;
  localparam logic [3:0] PosPb0  = 4'd3;
  localparam logic [3:0] PosPb1  = 4'd4;
  localparam logic [3:0] PosPb2  = 4'd5;
  localparam logic [3:0] PosPb3  = 4'd6;
  localparam logic [3:0] PosPb4  = 4'd7;
  localparam logic [3:0] PosPb5  = 4'd8;
  localparam logic [3:0] PosPb6  = 4'd9;

endpackage

// ----- rtl/core/hdmi_vsif_packet_builder_core.sv -----
// ----------------------------------------------------------------------------
// hdmi_vsif_packet_builder_core
// The first byte passes the front descriptor register, queue entry and output
// register. The byte sequencer emits one byte per cycle while out_stall is
// low; 9 bytes per request, 10 for side-by-side, 1 when no packet is sent.
// Reset: synchronous, active low; clears the valid flags, queue pointers
// and byte counter.
// ----------------------------------------------------------------------------
module hdmi_vsif_packet_builder_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  vsif_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output vsif_pkg::out_t out_data
);

  logic            push;
  vsif_pkg::desc_t push_desc;
  logic            q_full;
  logic            pop;
  logic            not_empty;
  vsif_pkg::desc_t head;

  vsif_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_desc (push_desc),
    .q_full    (q_full)
  );

  vsif_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  vsif_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/vsif_front.sv -----
// ----------------------------------------------------------------------------
// vsif_front
// Accepts a timing request and reduces it to a packet descriptor.
// ----------------------------------------------------------------------------
module vsif_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  vsif_pkg::in_t  in_data,
  output logic           push,
  output vsif_pkg::desc_t push_desc,
  input  logic           q_full
);

  logic            valid_r, valid_nxt;
  vsif_pkg::desc_t desc_r;
  vsif_pkg::desc_t desc_c;
  logic            accept;
  logic            vic_mode;
  logic [7:0]      len;
  logic [7:0]      sum;

  always_comb begin
    vic_mode = (in_data.ext_vic != 8'd0) &&
               (in_data.horiz_total >= vsif_pkg::VicMinHtot) &&
               (in_data.vert_total >= vsif_pkg::VicMinVtot);
    desc_c.sent = (in_data.format_3d != vsif_pkg::F3dNone) || vic_mode;
    desc_c.pb4  = (in_data.format_3d != vsif_pkg::F3dNone) ? vsif_pkg::Fmt3d
                                                         : vsif_pkg::FmtExtRes;
    desc_c.len6 = 1'b0;
    case (in_data.format_3d) inside
      vsif_pkg::F3dSbs, vsif_pkg::F3dSbsSw: begin
        desc_c.pb5  = vsif_pkg::StructSbs;
        desc_c.len6 = 1'b1;
      end
      vsif_pkg::F3dTb, vsif_pkg::F3dTbSw: begin
        desc_c.pb5 = vsif_pkg::StructTb;
      end
      default: begin
        desc_c.pb5 = 8'h00;
      end
    endcase
    if (vic_mode) begin
      desc_c.pb5 = in_data.ext_vic;
    end
    len = desc_c.len6 ? vsif_pkg::LenSbs : vsif_pkg::LenNormal;
    sum = vsif_pkg::VsifType + vsif_pkg::VsifVersion + len + vsif_pkg::OuiByte0 +
          vsif_pkg::OuiByte1 + vsif_pkg::OuiByte2 + desc_c.pb4 + desc_c.pb5;
    desc_c.csum = 8'h00 - sum;
  end

  assign in_stall  = valid_r && q_full;
  assign accept    = in_valid && !in_stall;
  assign push      = valid_r && !q_full;
  assign push_desc = desc_r;
  assign valid_nxt = accept || (valid_r && !push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      desc_r <= desc_c;
    end
  end

endmodule

// ----- rtl/core/vsif_queue.sv -----
// ----------------------------------------------------------------------------
// vsif_queue
// Two-entry descriptor queue between the front and the byte sequencer.
// ----------------------------------------------------------------------------
module vsif_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  vsif_pkg::desc_t push_desc,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output vsif_pkg::desc_t head
);

  vsif_pkg::desc_t ent_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ----- rtl/core/vsif_back.sv -----
// ----------------------------------------------------------------------------
// vsif_back
// Byte sequencer: walks a descriptor out one packet byte per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module vsif_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            not_empty,
  input  vsif_pkg::desc_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output vsif_pkg::out_t  out_data
);

  logic           out_valid_r, out_valid_nxt;
  vsif_pkg::out_t out_r;
  vsif_pkg::out_t res_c;
  logic [3:0]     pos_r, pos_nxt;
  logic           load;
  logic           last;
  logic [3:0]     last_pos;

  assign load     = not_empty && (!out_valid_r || !out_stall);
  assign last_pos = head.len6 ? vsif_pkg::PosPb6 : vsif_pkg::PosPb5;
  assign last     = !head.sent || (pos_r == last_pos);
  assign pop      = load && last;

  always_comb begin
    res_c.packet_sent = head.sent;
    res_c.byte_pos    = head.sent ? pos_r : 4'd0;
    res_c.last_byte   = last;
    unique case (pos_r)
      vsif_pkg::PosHb0: res_c.byte_value = vsif_pkg::VsifType;
      vsif_pkg::PosHb1: res_c.byte_value = vsif_pkg::VsifVersion;
      vsif_pkg::PosHb2: res_c.byte_value = head.len6 ? vsif_pkg::LenSbs
                                                     : vsif_pkg::LenNormal;
      vsif_pkg::PosPb0: res_c.byte_value = head.csum;
      vsif_pkg::PosPb1: res_c.byte_value = vsif_pkg::OuiByte0;
      vsif_pkg::PosPb2: res_c.byte_value = vsif_pkg::OuiByte1;
      vsif_pkg::PosPb3: res_c.byte_value = vsif_pkg::OuiByte2;
      vsif_pkg::PosPb4: res_c.byte_value = head.pb4;
      vsif_pkg::PosPb5: res_c.byte_value = head.pb5;
      default:          res_c.byte_value = 8'h00;
    endcase
    if (!head.sent) begin
      res_c.byte_value = 8'h00;
    end
    pos_nxt = pos_r;
    if (load) begin
      pos_nxt = last ? vsif_pkg::PosHb0 : pos_r + 4'd1;
    end
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= vsif_pkg::PosHb0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
